>>> src/arm_pkg.sv
// Shared types, constants and arithmetic helpers for the axis-angle rotation matrix block.
package arm_pkg;

   localparam int FRAC_BITS_DEF    = 14;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 32;
   localparam int AXIS_W           = 16;
   localparam int ANGLE_W          = 16;
   localparam int ENTRY_W          = 16;
   localparam int XY_W             = 34;
   localparam int Z_W              = 34;
   localparam int T_W              = 35;
   localparam int PP_W             = 2 * AXIS_W;
   localparam int ACC_W            = 70;

   localparam logic signed [XY_W-1:0]  GAIN_Q30 = 34'sh026DD3B6A;
   localparam logic signed [T_W-1:0]   ONE_Q30  = 35'sh040000000;
   localparam logic signed [ACC_W-1:0] HALF_Q30 = 70'sh20000000;
   localparam logic signed [ACC_W-1:0] SAT_HI   = 70'sd32767;
   localparam logic signed [ACC_W-1:0] SAT_LO   = -70'sd32768;

   typedef logic signed [AXIS_W-1:0]  axis_comp_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;

   typedef struct packed {
      axis_comp_type x;
      axis_comp_type y;
      axis_comp_type z;
   } axis_type;

   typedef struct packed {
      entry_type m00;
      entry_type m01;
      entry_type m02;
      entry_type m10;
      entry_type m11;
      entry_type m12;
      entry_type m20;
      entry_type m21;
      entry_type m22;
   } matrix_type;

   function automatic logic signed [Z_W-1:0] atan_at(input int idx);
      logic [31:0] v;
      case (idx)
         0:       v = 32'h20000000;
         1:       v = 32'h12E4051E;
         2:       v = 32'h09FB385B;
         3:       v = 32'h051111D4;
         4:       v = 32'h028B0D43;
         5:       v = 32'h0145D7E1;
         6:       v = 32'h00A2F61E;
         7:       v = 32'h00517C55;
         8:       v = 32'h0028BE53;
         9:       v = 32'h00145F2F;
         10:      v = 32'h000A2F98;
         11:      v = 32'h000517CC;
         12:      v = 32'h00028BE6;
         13:      v = 32'h000145F3;
         14:      v = 32'h0000A2FA;
         15:      v = 32'h0000517D;
         16:      v = 32'h000028BE;
         17:      v = 32'h0000145F;
         18:      v = 32'h00000A30;
         19:      v = 32'h00000518;
         20:      v = 32'h0000028C;
         21:      v = 32'h00000146;
         22:      v = 32'h000000A3;
         23:      v = 32'h00000051;
         24:      v = 32'h00000029;
         25:      v = 32'h00000014;
         26:      v = 32'h0000000A;
         27:      v = 32'h00000005;
         28:      v = 32'h00000003;
         29:      v = 32'h00000001;
         30:      v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return {{(Z_W-32){1'b0}}, v};
   endfunction

   function automatic logic signed [ACC_W-1:0] mul_su(input logic signed [XY_W-1:0] s,
                                                      input axis_comp_type u);
      logic signed [XY_W+AXIS_W-1:0] p;
      p = s * u;
      return ACC_W'(p);
   endfunction

   function automatic logic signed [ACC_W-1:0] mul_tp(input logic signed [T_W-1:0] t,
                                                      input logic signed [PP_W-1:0] pp,
                                                      input int frac);
      logic signed [T_W+PP_W-1:0] p;
      p = t * pp;
      p = p >>> frac;
      return ACC_W'(p);
   endfunction

   function automatic entry_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] q;
      q = (acc + HALF_Q30) >>> 30;
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return q[ENTRY_W-1:0];
   endfunction

endpackage

>>> src/arm_ifaces.sv
// Request and response channel interfaces.
interface arm_req_if;
   import arm_pkg::*;
   logic          valid;
   logic          ready;
   axis_comp_type axis_x;
   axis_comp_type axis_y;
   axis_comp_type axis_z;
   logic [ANGLE_W-1:0] turn_angle;
   modport source (output valid, axis_x, axis_y, axis_z, turn_angle, input ready);
   modport sink   (input valid, axis_x, axis_y, axis_z, turn_angle, output ready);
endinterface

interface arm_rsp_if;
   import arm_pkg::*;
   logic      valid;
   logic      ready;
   entry_type m00;
   entry_type m01;
   entry_type m02;
   entry_type m10;
   entry_type m11;
   entry_type m12;
   entry_type m20;
   entry_type m21;
   entry_type m22;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

>>> src/arm_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage, giving sine and cosine.
module arm_cordic #(
   parameter int CORDIC_STEPS = arm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [arm_pkg::ANGLE_W-1:0]       in_angle,
   input  arm_pkg::axis_type                 in_axis,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [arm_pkg::XY_W-1:0]   out_sin,
   output logic signed [arm_pkg::XY_W-1:0]   out_cos,
   output arm_pkg::axis_type                 out_axis
);
   import arm_pkg::*;

   localparam int N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   logic                   v_ff    [0:N];
   logic signed [XY_W-1:0] x_ff    [0:N];
   logic signed [XY_W-1:0] y_ff    [0:N];
   logic signed [Z_W-1:0]  z_ff    [0:N];
   axis_type               axis_ff [0:N];
   logic                   flip_ff [0:N];
   logic                   en      [0:N+1];

   logic                   flip_in;
   logic [ANGLE_W-1:0]     ang_in;
   logic signed [Z_W-1:0]  z0_in;

   always_comb begin
      en[N+1] = out_ready;
      for (int k = N; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   // second and third quadrant: turn by half a turn, negate at the end
   always_comb begin
      flip_in = in_angle[ANGLE_W-1] ^ in_angle[ANGLE_W-2];
      ang_in  = flip_in ? (in_angle ^ {1'b1, {(ANGLE_W-1){1'b0}}}) : in_angle;
      z0_in   = {{(Z_W-32){ang_in[ANGLE_W-1]}}, ang_in, {(32-ANGLE_W){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
      if (en[0]) begin
         x_ff[0]    <= GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_in;
         axis_ff[0] <= in_axis;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      logic signed [Z_W-1:0]  z_in;

      always_comb begin
         if (!z_ff[k-1][Z_W-1]) begin
            x_in = x_ff[k-1] - (y_ff[k-1] >>> (k-1));
            y_in = y_ff[k-1] + (x_ff[k-1] >>> (k-1));
            z_in = z_ff[k-1] - atan_at(k-1);
         end else begin
            x_in = x_ff[k-1] + (y_ff[k-1] >>> (k-1));
            y_in = y_ff[k-1] - (x_ff[k-1] >>> (k-1));
            z_in = z_ff[k-1] + atan_at(k-1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (en[k]) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            z_ff[k]    <= z_in;
            axis_ff[k] <= axis_ff[k-1];
            flip_ff[k] <= flip_ff[k-1];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[N];
   assign out_sin   = flip_ff[N] ? -y_ff[N] : y_ff[N];
   assign out_cos   = flip_ff[N] ? -x_ff[N] : x_ff[N];
   assign out_axis  = axis_ff[N];

endmodule

>>> src/arm_combine.sv
// Rodrigues combination: axis products, scaling by sine and 1-cos, rounding and saturation.
module arm_combine #(
   parameter int FRAC_BITS = arm_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [arm_pkg::XY_W-1:0]  in_sin,
   input  logic signed [arm_pkg::XY_W-1:0]  in_cos,
   input  arm_pkg::axis_type                in_axis,
   output logic                             out_valid,
   input  logic                             out_ready,
   output arm_pkg::matrix_type              out_mat
);
   import arm_pkg::*;

   logic                    en_a, en_b, en_c;

   logic                    va_ff;
   logic signed [XY_W-1:0]  s_a_ff, c_a_ff;
   logic signed [T_W-1:0]   t_a_ff;
   axis_type                axis_a_ff;
   logic signed [PP_W-1:0]  pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;

   logic                    vb_ff;
   logic signed [ACC_W-1:0] txx_ff, tyy_ff, tzz_ff, txy_ff, txz_ff, tyz_ff;
   logic signed [ACC_W-1:0] sux_ff, suy_ff, suz_ff, cd_ff;

   logic                    vc_ff;
   matrix_type              mat_ff;
   matrix_type              mat_in;

   assign en_c     = !vc_ff || out_ready;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= in_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         s_a_ff    <= in_sin;
         c_a_ff    <= in_cos;
         t_a_ff    <= ONE_Q30 - T_W'(in_cos);
         axis_a_ff <= in_axis;
         pxx_ff    <= in_axis.x * in_axis.x;
         pyy_ff    <= in_axis.y * in_axis.y;
         pzz_ff    <= in_axis.z * in_axis.z;
         pxy_ff    <= in_axis.x * in_axis.y;
         pxz_ff    <= in_axis.x * in_axis.z;
         pyz_ff    <= in_axis.y * in_axis.z;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         txx_ff <= mul_tp(t_a_ff, pxx_ff, FRAC_BITS);
         tyy_ff <= mul_tp(t_a_ff, pyy_ff, FRAC_BITS);
         tzz_ff <= mul_tp(t_a_ff, pzz_ff, FRAC_BITS);
         txy_ff <= mul_tp(t_a_ff, pxy_ff, FRAC_BITS);
         txz_ff <= mul_tp(t_a_ff, pxz_ff, FRAC_BITS);
         tyz_ff <= mul_tp(t_a_ff, pyz_ff, FRAC_BITS);
         sux_ff <= mul_su(s_a_ff, axis_a_ff.x);
         suy_ff <= mul_su(s_a_ff, axis_a_ff.y);
         suz_ff <= mul_su(s_a_ff, axis_a_ff.z);
         cd_ff  <= ACC_W'(c_a_ff) <<< FRAC_BITS;
      end
   end

   always_comb begin
      mat_in.m00 = round_sat(txx_ff + cd_ff);
      mat_in.m01 = round_sat(txy_ff - suz_ff);
      mat_in.m02 = round_sat(txz_ff + suy_ff);
      mat_in.m10 = round_sat(txy_ff + suz_ff);
      mat_in.m11 = round_sat(tyy_ff + cd_ff);
      mat_in.m12 = round_sat(tyz_ff - sux_ff);
      mat_in.m20 = round_sat(txz_ff - suy_ff);
      mat_in.m21 = round_sat(tyz_ff + sux_ff);
      mat_in.m22 = round_sat(tzz_ff + cd_ff);
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         mat_ff <= mat_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_mat   = mat_ff;

endmodule

>>> src/axis_angle_rotation_matrix.sv
// Top level: axis-angle (Rodrigues) rotation matrix from a unit axis and a binary angle.
// Pipeline: angle setup, one CORDIC iteration per stage, axis products, scaling
// multiplies, round and saturate into the output register.
// Throughput: one transaction per cycle; a full stage holds while the next one stalls.
// Reset clears the stage valid bits only; no data state survives between transactions.
module axis_angle_rotation_matrix #(
   parameter int FRAC_BITS    = arm_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = arm_pkg::CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   arm_req_if.sink   req_chan,
   arm_rsp_if.source rsp_chan
);
   import arm_pkg::*;

   axis_type               req_axis;
   logic                   cor_valid, cor_ready;
   logic signed [XY_W-1:0] cor_sin, cor_cos;
   axis_type               cor_axis;
   matrix_type             mat;

   assign req_axis.x = req_chan.axis_x;
   assign req_axis.y = req_chan.axis_y;
   assign req_axis.z = req_chan.axis_z;

   arm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_angle  (req_chan.turn_angle),
      .in_axis   (req_axis),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .out_sin   (cor_sin),
      .out_cos   (cor_cos),
      .out_axis  (cor_axis)
   );

   arm_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .in_ready  (cor_ready),
      .in_sin    (cor_sin),
      .in_cos    (cor_cos),
      .in_axis   (cor_axis),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_mat   (mat)
   );

   assign rsp_chan.m00 = mat.m00;
   assign rsp_chan.m01 = mat.m01;
   assign rsp_chan.m02 = mat.m02;
   assign rsp_chan.m10 = mat.m10;
   assign rsp_chan.m11 = mat.m11;
   assign rsp_chan.m12 = mat.m12;
   assign rsp_chan.m20 = mat.m20;
   assign rsp_chan.m21 = mat.m21;
   assign rsp_chan.m22 = mat.m22;

endmodule

>>> src/arm_checker.sv
// Port-level checks for the rotation matrix block, bound to the top level.
module arm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [arm_pkg::ENTRY_W-1:0] rsp_m00,
   input logic [arm_pkg::ENTRY_W-1:0] rsp_m11
);
   import arm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_m00) && $stable(rsp_m11))
      else $error("response payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_no_false_stall: assert property (@(posedge clock)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled while output drains");

endmodule

bind axis_angle_rotation_matrix arm_checker u_arm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_m00   (rsp_chan.m00),
   .rsp_m11   (rsp_chan.m11)
);
